### hw/rtl/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types, register codes and constants for the mask-to-RGBA converter.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int unsigned NumChan  = 4;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned DimRegW  = 13;
  localparam int unsigned IndexW   = 24;

  typedef enum logic [RegIdxW-1:0] {
    REG_MASK_RED        = 3'd0,
    REG_MASK_GREEN      = 3'd1,
    REG_MASK_BLUE       = 3'd2,
    REG_MASK_ALPHA      = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_FLIP_VERTICAL   = 3'd6,
    REG_FLIP_HORIZONTAL = 3'd7
  } cfg_reg_e;

  localparam logic [DataW-1:0] ALPHA_OPAQUE = 32'hff00_0000;

  localparam logic [ShiftW-1:0] CHAN_BASE [NumChan] = '{5'd0, 5'd8, 5'd16, 5'd24};

  localparam logic [DataW-1:0] MASK_RESET [NumChan] =
    '{32'h0000_00ff, 32'h0000_ff00, 32'h00ff_0000, 32'hff00_0000};

  // Per-channel setup, derived at reset and when the mask is written.
  typedef struct packed {
    logic [DataW-1:0]  mask;
    logic              zero;
    logic [ShiftW-1:0] rsh;
    logic [ShiftW-1:0] lsh;
  } chan_cfg_t;

  function automatic logic [ShiftW-1:0] lead_one(input logic [DataW-1:0] v);
    logic [ShiftW-1:0] pos;
    pos = '0;
    for (int i = 0; i < DataW; i++) begin
      if (v[i]) begin
        pos = ShiftW'(i);
      end
    end
    return pos;
  endfunction

  // Right shift drops the mask top bit to bit 7, left shift puts bit 7 of the
  // 8-bit field at the top of the channel byte.
  function automatic chan_cfg_t chan_derive(input logic [DataW-1:0]  mask,
                                            input logic [ShiftW-1:0] base);
    chan_cfg_t         c;
    logic [ShiftW-1:0] msb;
    msb    = lead_one(mask);
    c.mask = mask;
    c.zero = (mask == '0);
    if (msb > 5'd7) begin
      c.rsh = msb - 5'd7;
      c.lsh = base;
    end else begin
      c.rsh = '0;
      c.lsh = base + (5'd7 - msb);
    end
    return c;
  endfunction

endpackage

### hw/rtl/mpr_cfg.sv
// ----------------------------------------------------------------------------
// mpr_cfg
// Configuration registers: channel masks with their shifts, clamped image
// dimensions and mirror flags.
// ----------------------------------------------------------------------------
module mpr_cfg #(
  parameter int unsigned MAX_DIM = 4096,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned DW = $clog2(MAX_DIM + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mpr_pkg::RegIdxW-1:0]         cfg_index_i,
  input  logic [mpr_pkg::DataW-1:0]           cfg_wdata_i,
  output mpr_pkg::chan_cfg_t                  chan_o [mpr_pkg::NumChan],
  output logic [DW-1:0]                       width_o,
  output logic [CW-1:0]                       width_last_o,
  output logic [CW-1:0]                       height_last_o,
  output logic                                flip_v_o,
  output logic                                flip_h_o
);

  mpr_pkg::chan_cfg_t chan_q [mpr_pkg::NumChan];
  logic [DW-1:0] width_q;
  logic [CW-1:0] width_last_q, height_last_q;
  logic          flip_v_q, flip_h_q;

  logic [mpr_pkg::DimRegW-1:0] dim_raw;
  logic [DW-1:0]               dim_clamp;

  // 0 reads as 1, anything above MAX_DIM as MAX_DIM
  assign dim_raw = cfg_wdata_i[mpr_pkg::DimRegW-1:0];

  always_comb begin
    if (dim_raw == '0) begin
      dim_clamp = DW'(1);
    end else if (32'(dim_raw) > 32'(MAX_DIM)) begin
      dim_clamp = DW'(MAX_DIM);
    end else begin
      dim_clamp = DW'(dim_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mpr_pkg::NumChan; c++) begin
        chan_q[c] <= mpr_pkg::chan_derive(mpr_pkg::MASK_RESET[c], mpr_pkg::CHAN_BASE[c]);
      end
      width_q       <= DW'(1);
      width_last_q  <= '0;
      height_last_q <= '0;
      flip_v_q      <= 1'b0;
      flip_h_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mpr_pkg::REG_MASK_RED: begin
          chan_q[0] <= mpr_pkg::chan_derive(cfg_wdata_i, mpr_pkg::CHAN_BASE[0]);
        end
        mpr_pkg::REG_MASK_GREEN: begin
          chan_q[1] <= mpr_pkg::chan_derive(cfg_wdata_i, mpr_pkg::CHAN_BASE[1]);
        end
        mpr_pkg::REG_MASK_BLUE: begin
          chan_q[2] <= mpr_pkg::chan_derive(cfg_wdata_i, mpr_pkg::CHAN_BASE[2]);
        end
        mpr_pkg::REG_MASK_ALPHA: begin
          chan_q[3] <= mpr_pkg::chan_derive(cfg_wdata_i, mpr_pkg::CHAN_BASE[3]);
        end
        mpr_pkg::REG_IMAGE_WIDTH: begin
          width_q      <= dim_clamp;
          width_last_q <= CW'(dim_clamp - DW'(1));
        end
        mpr_pkg::REG_IMAGE_HEIGHT: begin
          height_last_q <= CW'(dim_clamp - DW'(1));
        end
        mpr_pkg::REG_FLIP_VERTICAL: begin
          flip_v_q <= cfg_wdata_i[0];
        end
        mpr_pkg::REG_FLIP_HORIZONTAL: begin
          flip_h_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign chan_o        = chan_q;
  assign width_o       = width_q;
  assign width_last_o  = width_last_q;
  assign height_last_o = height_last_q;
  assign flip_v_o      = flip_v_q;
  assign flip_h_o      = flip_h_q;

endmodule

### hw/rtl/mpr_scan.sv
// ----------------------------------------------------------------------------
// mpr_scan
// Column and row counters in scan order; gives the mirrored destination
// position and the end-of-image flag for the current request.
// ----------------------------------------------------------------------------
module mpr_scan #(
  parameter int unsigned MAX_DIM = 4096,
  localparam int unsigned CW = $clog2(MAX_DIM)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  logic [CW-1:0] width_last_i,
  input  logic [CW-1:0] height_last_i,
  input  logic          flip_v_i,
  input  logic          flip_h_i,
  output logic [CW-1:0] dcol_o,
  output logic [CW-1:0] drow_o,
  output logic          frame_last_o
);

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] col, row;
  logic          end_row, end_img;

  // a counter left past a shrunk dimension acts as the last column/row
  assign col = (col_q > width_last_i)  ? width_last_i  : col_q;
  assign row = (row_q > height_last_i) ? height_last_i : row_q;

  assign end_row = (col == width_last_i);
  assign end_img = end_row && (row == height_last_i);

  assign dcol_o       = flip_h_i ? (width_last_i - col)  : col;
  assign drow_o       = flip_v_i ? (height_last_i - row) : row;
  assign frame_last_o = end_img;

  always_comb begin
    if (end_img) begin
      col_d = '0;
      row_d = '0;
    end else if (end_row) begin
      col_d = '0;
      row_d = row + CW'(1);
    end else begin
      col_d = col + CW'(1);
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hw/rtl/mpr_chan.sv
// ----------------------------------------------------------------------------
// mpr_chan
// One channel extractor: mask the raw pixel, bring the field to eight bits
// and place it in the channel byte of the RGBA word.
// ----------------------------------------------------------------------------
module mpr_chan #(
  parameter bit IS_ALPHA = 1'b0
) (
  input  logic [mpr_pkg::DataW-1:0] raw_i,
  input  mpr_pkg::chan_cfg_t        cfg_i,
  output logic [mpr_pkg::DataW-1:0] chan_o
);

  logic [mpr_pkg::DataW-1:0] shifted;
  logic [7:0]                field;

  assign shifted = (raw_i & cfg_i.mask) >> cfg_i.rsh;
  assign field   = shifted[7:0];

  always_comb begin
    if (cfg_i.zero) begin
      chan_o = IS_ALPHA ? mpr_pkg::ALPHA_OPAQUE : '0;
    end else begin
      chan_o = mpr_pkg::DataW'(field) << cfg_i.lsh;
    end
  end

endmodule

### hw/rtl/mask_pixel_to_rgba.sv
// ----------------------------------------------------------------------------
// mask_pixel_to_rgba
// Bit-mask pixel format conversion to RGBA8888 with destination indexing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: raw_pixel_i with in_valid_i / in_stall_o, one raw pixel per
//   request in scan order. Output channel: rgba_word_o, pixel_index_o and
//   frame_last_o with out_valid_o / out_stall_i, one result per request.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (masks, width, height, mirror flags); write only while no request is in
//   flight.
//   Pipeline: two register stages in all (input register, output register);
//   a taken request passes through both before it is presented.
//   Throughput: one pixel per clock without output stall; the critical path
//   is the row times width multiply plus column add feeding output register.
//   Stall: while out_stall_i holds the output register, the input register
//   still takes one more request; in_stall_o rises only when both are full.
//   Reset: masks return to 8-bit R,G,B,A lanes, 1x1 image, no mirroring,
//   counters at the first pixel, both stages empty.
// ----------------------------------------------------------------------------
module mask_pixel_to_rgba #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpr_pkg::RegIdxW-1:0]       cfg_index_i,
  input  logic [mpr_pkg::DataW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mpr_pkg::DataW-1:0]         raw_pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mpr_pkg::DataW-1:0]         rgba_word_o,
  output logic [mpr_pkg::IndexW-1:0]        pixel_index_o,
  output logic                              frame_last_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned PW = CW + DW + 1;

  mpr_pkg::chan_cfg_t chan_cfg [mpr_pkg::NumChan];
  logic [DW-1:0] width;
  logic [CW-1:0] width_last, height_last;
  logic          flip_v, flip_h;

  logic [CW-1:0] dcol, drow;
  logic          scan_last;

  logic in_accept, s1_move, s2_free;

  // input register
  logic                      s1_valid_q;
  logic [mpr_pkg::DataW-1:0] raw_q;
  logic [CW-1:0]             dcol_q, drow_q;
  logic                      last_q;

  // output register
  logic                       s2_valid_q;
  logic [mpr_pkg::DataW-1:0]  rgba_q, rgba_d;
  logic [mpr_pkg::IndexW-1:0] index_q, index_d;
  logic                       frame_last_q;

  logic [mpr_pkg::DataW-1:0] chan_word [mpr_pkg::NumChan];
  logic [PW-1:0]             index_full;

  mpr_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .chan_o        (chan_cfg),
    .width_o       (width),
    .width_last_o  (width_last),
    .height_last_o (height_last),
    .flip_v_o      (flip_v),
    .flip_h_o      (flip_h)
  );

  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  mpr_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (in_accept),
    .width_last_i  (width_last),
    .height_last_i (height_last),
    .flip_v_i      (flip_v),
    .flip_h_i      (flip_h),
    .dcol_o        (dcol),
    .drow_o        (drow),
    .frame_last_o  (scan_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q  <= raw_pixel_i;
      dcol_q <= dcol;
      drow_q <= drow;
      last_q <= scan_last;
    end
  end

  for (genvar c = 0; c < mpr_pkg::NumChan; c++) begin : g_chan
    mpr_chan #(
      .IS_ALPHA (c == mpr_pkg::NumChan - 1)
    ) u_chan (
      .raw_i  (raw_q),
      .cfg_i  (chan_cfg[c]),
      .chan_o (chan_word[c])
    );
  end

  assign rgba_d = chan_word[0] | chan_word[1] | chan_word[2] | chan_word[3];

  assign index_full = (PW'(drow_q) * PW'(width)) + PW'(dcol_q);
  assign index_d    = mpr_pkg::IndexW'(index_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      rgba_q       <= rgba_d;
      index_q      <= index_d;
      frame_last_q <= last_q;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign rgba_word_o   = rgba_q;
  assign pixel_index_o = index_q;
  assign frame_last_o  = frame_last_q;

endmodule

### test/tb_mask_pixel_to_rgba.sv
// ----------------------------------------------------------------------------
// tb_mask_pixel_to_rgba
// Self-checking bench for the mask-to-RGBA pixel converter. A directed table
// covers lane extremes, zero masks, mirroring, clamped dimensions and
// counters left past a shrunk image. Random phases with new register
// settings follow. Every result is checked against the table's value or an
// in-bench model under bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module tb_mask_pixel_to_rgba;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned NumRandom = 850;
  localparam int unsigned NumRows   = 48;

  typedef struct packed {
    logic [mpr_pkg::DataW-1:0]  rgba;
    logic [mpr_pkg::IndexW-1:0] index;
    logic                       last;
  } pixel_result_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    mpr_pkg::cfg_reg_e         addr;
    logic [mpr_pkg::DataW-1:0] data;
    logic                      typed;
    pixel_result_t             want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BURSTS
  } stall_mode_e;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [mpr_pkg::RegIdxW-1:0]  cfg_index = '0;
  logic [mpr_pkg::DataW-1:0]    cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [mpr_pkg::DataW-1:0]    raw_pixel = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mpr_pkg::DataW-1:0]    rgba_word;
  logic [mpr_pkg::IndexW-1:0]   pixel_index;
  logic                         frame_last;

  // model state
  logic [mpr_pkg::DataW-1:0]    mask_q [mpr_pkg::NumChan];
  logic [mpr_pkg::DimRegW-1:0]  width_q  = 13'd1;
  logic [mpr_pkg::DimRegW-1:0]  height_q = 13'd1;
  logic                         flip_v_q = 1'b0;
  logic                         flip_h_q = 1'b0;
  int unsigned                  col_q    = 0;
  int unsigned                  row_q    = 0;

  pixel_result_t       pending_q [$];
  stim_row_t           stim_rows [NumRows];
  int unsigned         mismatches  = 0;
  int unsigned         burst_left  = 0;
  int unsigned         pixels_sent = 0;
  stall_mode_e         stall_mode  = STALL_NONE;
  int unsigned         mode_left   = 0;
  int unsigned         stall_left  = 0;

  mask_pixel_to_rgba #(
    .MAX_DIM(MaxDim)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .raw_pixel_i  (raw_pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .rgba_word_o  (rgba_word),
    .pixel_index_o(pixel_index),
    .frame_last_o (frame_last)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(logic [mpr_pkg::DimRegW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic [mpr_pkg::DataW-1:0] chan_value(
    logic [mpr_pkg::DataW-1:0] raw, logic [mpr_pkg::DataW-1:0] mask, int ch);
    logic [mpr_pkg::DataW-1:0] t;
    int unsigned               rs;
    int unsigned               ls;
    if (mask == '0) return (ch == 3) ? mpr_pkg::ALPHA_OPAQUE : '0;
    t  = mask;
    rs = 0;
    ls = mpr_pkg::CHAN_BASE[ch];
    while (t[mpr_pkg::DataW-1:8] != '0) begin
      t = t >> 1;
      rs++;
    end
    while (!t[7]) begin
      t = {24'h0, t[6:0], 1'b0};
      ls++;
    end
    return ((raw & mask) >> rs) << ls;
  endfunction

  // Converts one pixel and advances the scan counters.
  function automatic pixel_result_t convert_next(logic [mpr_pkg::DataW-1:0] raw);
    pixel_result_t r;
    int unsigned   w, h, col, row, dcol, drow, idx;
    logic          end_row;
    w   = clamp_dim(width_q);
    h   = clamp_dim(height_q);
    col = (col_q >= w) ? w - 1 : col_q;
    row = (row_q >= h) ? h - 1 : row_q;
    r.rgba = '0;
    for (int c = 0; c < mpr_pkg::NumChan; c++) begin
      r.rgba = r.rgba | chan_value(raw, mask_q[c], c);
    end
    dcol    = flip_h_q ? w - 1 - col : col;
    drow    = flip_v_q ? h - 1 - row : row;
    idx     = drow * w + dcol;
    r.index = idx[mpr_pkg::IndexW-1:0];
    end_row = (col == w - 1);
    r.last  = end_row && (row == h - 1);
    if (r.last) begin
      col_q = 0;
      row_q = 0;
    end else if (end_row) begin
      col_q = 0;
      row_q = row + 1;
    end else begin
      col_q = col + 1;
      row_q = row;
    end
    return r;
  endfunction

  function automatic stim_row_t px(logic [mpr_pkg::DataW-1:0] raw);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_PIXEL;
    s.data = raw;
    return s;
  endfunction

  function automatic stim_row_t pxk(logic [mpr_pkg::DataW-1:0] raw,
                                    logic [mpr_pkg::DataW-1:0] rgba,
                                    logic [mpr_pkg::IndexW-1:0] index, logic last);
    stim_row_t s;
    s            = px(raw);
    s.typed      = 1'b1;
    s.want.rgba  = rgba;
    s.want.index = index;
    s.want.last  = last;
    return s;
  endfunction

  function automatic stim_row_t wr(mpr_pkg::cfg_reg_e addr, logic [mpr_pkg::DataW-1:0] data);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_WRITE;
    s.addr = addr;
    s.data = data;
    return s;
  endfunction

  function automatic logic [mpr_pkg::DataW-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [mpr_pkg::DataW-1:0] pick_mask(int ch);
    logic [63:0] m;
    int unsigned len;
    int unsigned lo;
    case ($urandom_range(0, 7))
      0: return mpr_pkg::MASK_RESET[ch];
      1: return '0;
      2: return '1;
      3: return 32'h1 << $urandom_range(0, 31);
      4: return $urandom();
      default: begin
        len = $urandom_range(1, 32);
        lo  = $urandom_range(0, 32 - len);
        m   = ((64'h1 << len) - 64'h1) << lo;
        return m[mpr_pkg::DataW-1:0];
      end
    endcase
  endfunction

  // Mostly small images so that frames end often.
  function automatic logic [mpr_pkg::DataW-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'd4096;
      2:       return $urandom_range(4097, 8191);
      3, 4:    return 32'd1;
      5:       return $urandom_range(9, 64);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [mpr_pkg::DataW-1:0] pick_value(mpr_pkg::cfg_reg_e addr);
    case (addr)
      mpr_pkg::REG_IMAGE_WIDTH, mpr_pkg::REG_IMAGE_HEIGHT:
        return ($urandom() & 32'hffff_e000) | pick_dim();
      mpr_pkg::REG_FLIP_VERTICAL, mpr_pkg::REG_FLIP_HORIZONTAL:
        return $urandom();
      default:
        return pick_mask(int'(addr));
    endcase
  endfunction

  // Stop sending and wait until every request has come back out.
  task automatic drain();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(mpr_pkg::cfg_reg_e addr, logic [mpr_pkg::DataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      mpr_pkg::REG_MASK_RED, mpr_pkg::REG_MASK_GREEN,
      mpr_pkg::REG_MASK_BLUE, mpr_pkg::REG_MASK_ALPHA:
        mask_q[int'(addr)] = data;
      mpr_pkg::REG_IMAGE_WIDTH:     width_q  = data[mpr_pkg::DimRegW-1:0];
      mpr_pkg::REG_IMAGE_HEIGHT:    height_q = data[mpr_pkg::DimRegW-1:0];
      mpr_pkg::REG_FLIP_VERTICAL:   flip_v_q = data[0];
      mpr_pkg::REG_FLIP_HORIZONTAL: flip_h_q = data[0];
      default: ;
    endcase
  endtask

  task automatic push_pixel(logic [mpr_pkg::DataW-1:0] raw, logic typed,
                            pixel_result_t want);
    int unsigned   gap;
    pixel_result_t r;
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    raw_pixel <= raw;
    do @(posedge clk); while (in_stall);
    r = convert_next(raw);
    pending_q.push_back(typed ? want : r);
    pixels_sent++;
  endtask

  // Output side: check accepted results, then pick the next stall value.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: rgba %h index %h last %b",
                 $time, rgba_word, pixel_index, frame_last);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (rgba_word !== want.rgba) begin
          $display("%0t rgba_word: expected %h actual %h", $time, want.rgba, rgba_word);
          mismatches++;
        end
        if (pixel_index !== want.index) begin
          $display("%0t pixel_index: expected %h actual %h",
                   $time, want.index, pixel_index);
          mismatches++;
        end
        if (frame_last !== want.last) begin
          $display("%0t frame_last: expected %b actual %b", $time, want.last, frame_last);
          mismatches++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
      default: begin
        if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    endcase
  end

  initial begin
    int unsigned n;
    int unsigned start;
    foreach (mask_q[c]) mask_q[c] = mpr_pkg::MASK_RESET[c];
    stim_rows = '{
      // reset setting: 8-bit lanes, 1x1 image
      pxk(32'h0000_0000, 32'h0000_0000, 24'h0, 1'b1),
      pxk(32'hffff_ffff, 32'hffff_ffff, 24'h0, 1'b1),
      pxk(32'h8040_2010, 32'h8040_2010, 24'h0, 1'b1),
      // all masks zero: alpha opaque, colors black
      wr(mpr_pkg::REG_MASK_RED, 32'h0), wr(mpr_pkg::REG_MASK_GREEN, 32'h0),
      wr(mpr_pkg::REG_MASK_BLUE, 32'h0), wr(mpr_pkg::REG_MASK_ALPHA, 32'h0),
      pxk(32'hffff_ffff, 32'hff00_0000, 24'h0, 1'b1),
      // 565 layout, upper bits outside every mask
      wr(mpr_pkg::REG_MASK_RED, 32'h0000_f800), wr(mpr_pkg::REG_MASK_GREEN, 32'h0000_07e0),
      wr(mpr_pkg::REG_MASK_BLUE, 32'h0000_001f),
      px(32'h0000_ffff), px(32'hffff_0000),
      // single-bit and full-width masks
      wr(mpr_pkg::REG_MASK_RED, 32'h0000_0001), wr(mpr_pkg::REG_MASK_GREEN, 32'h8000_0000),
      wr(mpr_pkg::REG_MASK_BLUE, 32'h0000_0100), wr(mpr_pkg::REG_MASK_ALPHA, 32'hffff_ffff),
      px(32'hffff_ffff), px(32'h8000_0001),
      // 3x2 image in scan order, then mirrored both ways
      wr(mpr_pkg::REG_IMAGE_WIDTH, 32'd3), wr(mpr_pkg::REG_IMAGE_HEIGHT, 32'd2),
      px(32'h1234_5678), px(32'h9abc_def0), px(32'h0f0f_0f0f),
      px(32'hf0f0_f0f0), px(32'h5555_aaaa), px(32'haaaa_5555),
      wr(mpr_pkg::REG_FLIP_HORIZONTAL, 32'd1), wr(mpr_pkg::REG_FLIP_VERTICAL, 32'd1),
      px(32'h0000_0001), px(32'h0000_0100), px(32'h0001_0000),
      px(32'h0100_0000), px(32'h7fff_ffff), px(32'hffff_fffe),
      // zero dimensions act as 1
      wr(mpr_pkg::REG_IMAGE_WIDTH, 32'd0), wr(mpr_pkg::REG_IMAGE_HEIGHT, 32'd0),
      px(32'hdead_beef),
      // oversize width clamps to the largest image, index at its top
      wr(mpr_pkg::REG_IMAGE_WIDTH, 32'hffff_ffff),
      wr(mpr_pkg::REG_IMAGE_HEIGHT, 32'h0000_1000),
      px(32'hc3c3_c3c3), px(32'h3c3c_3c3c),
      // shrink while column sits past the new width
      wr(mpr_pkg::REG_IMAGE_WIDTH, 32'd2), wr(mpr_pkg::REG_IMAGE_HEIGHT, 32'd3),
      px(32'h0123_4567), px(32'h89ab_cdef),
      wr(mpr_pkg::REG_FLIP_VERTICAL, 32'hffff_fffe),
      wr(mpr_pkg::REG_FLIP_HORIZONTAL, 32'h0)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(stim_rows[i].addr, stim_rows[i].data);
      end else begin
        push_pixel(stim_rows[i].data, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases; counters carry over when dimensions change mid-image.
    start = pixels_sent;
    while (pixels_sent - start < NumRandom) begin
      drain();
      for (int r = 0; r < mpr_pkg::NumChan + 4; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(mpr_pkg::cfg_reg_e'(r), pick_value(mpr_pkg::cfg_reg_e'(r)));
        end
      end
      n = $urandom_range(20, 120);
      repeat (n) push_pixel(pick_raw(), 1'b0, '0);
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("** mask_pixel_to_rgba: PASSED **");
    end else begin
      $display("** mask_pixel_to_rgba: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t run did not complete", $time);
    $display("** mask_pixel_to_rgba: FAILED **");
    $finish;
  end

endmodule
